// ----- hw/rtl/lwacd_pkg.sv -----
package lwacd_pkg;

  // Field widths
  localparam int unsigned RawW = 24;
  localparam int unsigned LuxW = 18;

  // Model constants
  localparam int unsigned LuxDivisor     = 100;
  localparam int unsigned WindowResetVal = 400;
  localparam int unsigned ThreshResetVal = 90;
  localparam int unsigned WindowSizeDef  = 5;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b000_0001,
    ST_LUX      = 7'b000_0010,
    ST_READ     = 7'b000_0100,
    ST_DRAIN    = 7'b000_1000,
    ST_AVG_GO   = 7'b001_0000,
    ST_AVG_WAIT = 7'b010_0000,
    ST_RESULT   = 7'b100_0000
  } lwacd_state_e;

  // Window write request
  typedef struct packed {
    logic            en;
    logic [LuxW-1:0] data;
  } lwacd_wr_t;

endpackage

// ----- hw/rtl/lwacd_cdiv.sv -----
// Two-stage unsigned divide by a constant: reciprocal multiply, then one correction.
module lwacd_cdiv #(
  parameter int unsigned IN_W    = 24,
  parameter int unsigned Q_W     = 18,
  parameter int unsigned DIVISOR = 100
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IN_W-1:0] dividend_i,
  output logic            done_o,
  output logic [Q_W-1:0]  quotient_o
);

  // floor(2^IN_W / DIVISOR): estimate is exact or one low
  localparam longint unsigned Mult = (64'd1 << IN_W) / DIVISOR;
  localparam logic [IN_W-1:0] MultC = IN_W'(Mult);
  localparam logic [IN_W-1:0] DivC  = IN_W'(DIVISOR);

  logic [2*IN_W-1:0] prod_q;
  logic [IN_W-1:0]   x_q;
  logic              v1_q, done_q;
  logic [Q_W-1:0]    quot_q;
  logic [Q_W-1:0]    q_est;
  logic [IN_W-1:0]   rem;

  // Stage 1: reciprocal product
  always_ff @(posedge clk_i) begin
    prod_q <= (2*IN_W)'(dividend_i) * (2*IN_W)'(MultC);
    x_q    <= dividend_i;
  end

  // Stage 2: remainder check and fix-up
  assign q_est = prod_q[IN_W +: Q_W];
  assign rem   = x_q - IN_W'(IN_W'(q_est) * DivC);

  always_ff @(posedge clk_i) begin
    quot_q <= (rem >= DivC) ? q_est + Q_W'(1) : q_est;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      done_q <= v1_q;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// ----- hw/rtl/lwacd_window.sv -----
// Sample window: one write and one registered read per cycle.
// Entries never written since reset read as the reset value.
module lwacd_window #(
  parameter int unsigned WINDOW_SIZE = 5,
  parameter int unsigned SLOT_W      = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lwacd_pkg::lwacd_wr_t        wr_i,
  input  logic [SLOT_W-1:0]           wr_addr_i,
  input  logic [SLOT_W-1:0]           rd_addr_i,
  output logic [lwacd_pkg::LuxW-1:0]  rd_data_o
);
  import lwacd_pkg::*;

  logic [LuxW-1:0]        mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] valid_q;
  logic [LuxW-1:0]        rd_q;
  logic                   rd_vld_q;

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= wr_i.data;
    end
    rd_q <= mem[rd_addr_i];
  end

  // Written-since-reset flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : LuxW'(WindowResetVal);

endmodule

// ----- hw/rtl/light_weighted_average_change_detect_unit.sv -----
// Light-level change detector over a linearly weighted moving average.
//
// Input stream (s_axis): tdata carries the reading in hundredths of lux,
// tuser the sensor error flag. One request is taken at a time.
// Output stream (m_axis): tdata carries the weighted average in lux, tuser
// the change flag. Every input request gives exactly one output request.
// Config channel (cfg_*): writes the 18-bit change threshold; always ready,
// to be written while the block is idle.
//
// Each input passes through the lux divider, the window write, the window
// reads, a drain step and the average divider before its output is valid.
// The window memory is read one entry a cycle for the weighted sum, and
// both constant dividers are pipelined.
// A finished result sits in the output register; the next input is taken
// meanwhile, and the block stalls before its own output only if the
// previous one is still not taken.
// Reset: window reads as 400 lux per entry, slot pointer, last value and
// previous average go to zero, threshold to 90.
module light_weighted_average_change_detect_unit #(
  parameter int unsigned WINDOW_SIZE = lwacd_pkg::WindowSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] raw_reading
  input  logic [0:0]  s_axis_tuser,   // [0] reading_error
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] weighted_average, rest zero
  output logic [0:0]  m_axis_tuser,   // [0] change_detected
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [17:0] cfg_data_i      // change_threshold
);
  import lwacd_pkg::*;

  localparam int unsigned SlotW  = $clog2(WINDOW_SIZE);
  localparam int unsigned WtW    = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned DivSum = WINDOW_SIZE * (WINDOW_SIZE + 1) / 2;
  localparam int unsigned AccW   = LuxW + $clog2(DivSum);
  localparam logic [SlotW-1:0] NSlot    = SlotW'(WINDOW_SIZE);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW_SIZE - 1);

  lwacd_state_e    state_q, state_d;
  logic [LuxW-1:0] thresh_q;
  logic [LuxW-1:0] last_lux_q;
  logic [LuxW-1:0] prev_avg_q;
  logic [SlotW-1:0] slot_q;
  logic [SlotW-1:0] age_q;
  logic             err_q;
  logic             rd_pend_q;
  logic [WtW-1:0]   wt_q;
  logic [AccW-1:0]  acc_q;
  logic [LuxW-1:0]  avg_q;
  logic             out_valid_q;
  logic [LuxW-1:0]  out_avg_q;
  logic             out_chg_q;

  logic             in_req;
  logic             lux_done, avg_done;
  logic [LuxW-1:0]  lux_quot, avg_quot;
  logic [LuxW-1:0]  new_lux;
  lwacd_wr_t        win_wr;
  logic [SlotW-1:0] rd_addr;
  logic [LuxW-1:0]  rd_data;
  logic             out_load;
  logic [LuxW-1:0]  diff;
  logic             change;

  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Reading to lux
  lwacd_cdiv #(
    .IN_W    (RawW),
    .Q_W     (LuxW),
    .DIVISOR (LuxDivisor)
  ) u_lux_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_req),
    .dividend_i (s_axis_tdata),
    .done_o     (lux_done),
    .quotient_o (lux_quot)
  );

  // Weighted sum to average
  lwacd_cdiv #(
    .IN_W    (AccW),
    .Q_W     (LuxW),
    .DIVISOR (DivSum)
  ) u_avg_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_AVG_GO),
    .dividend_i (acc_q),
    .done_o     (avg_done),
    .quotient_o (avg_quot)
  );

  // Window write when the lux value is ready; reads start the next cycle
  assign new_lux     = err_q ? last_lux_q : lux_quot;
  assign win_wr.en   = (state_q == ST_LUX) && lux_done;
  assign win_wr.data = new_lux;

  // Read newest first: slot minus age, modulo window size
  assign rd_addr = (slot_q >= age_q) ? slot_q - age_q : SlotW'(slot_q + NSlot - age_q);

  lwacd_window #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SLOT_W      (SlotW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (win_wr),
    .wr_addr_i (slot_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Change decision on the finished average
  assign diff     = (avg_q > prev_avg_q) ? avg_q - prev_avg_q : prev_avg_q - avg_q;
  assign change   = (prev_avg_q != '0) && (diff > thresh_q) && !err_q;
  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_req) state_d = ST_LUX;
      ST_LUX:      if (lux_done) state_d = ST_READ;
      ST_READ:     if (age_q == LastSlot) state_d = ST_DRAIN;
      ST_DRAIN:    state_d = ST_AVG_GO;
      ST_AVG_GO:   state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: if (avg_done) state_d = ST_RESULT;
      ST_RESULT:   if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thresh_q    <= LuxW'(ThreshResetVal);
      last_lux_q  <= '0;
      prev_avg_q  <= '0;
      slot_q      <= '0;
      age_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      if (win_wr.en) begin
        last_lux_q <= new_lux;
      end
      // age counter walks the window during reads
      if (state_q == ST_READ) begin
        age_q <= (age_q == LastSlot) ? '0 : age_q + SlotW'(1);
      end else begin
        age_q <= '0;
      end
      rd_pend_q <= (state_q == ST_READ);
      if (out_load) begin
        prev_avg_q <= avg_q;
        if (!err_q) begin
          slot_q <= (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
        end
      end
      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      err_q <= s_axis_tuser[0];
    end
    wt_q <= WtW'(WINDOW_SIZE) - WtW'(age_q);
    // multiply-accumulate as read data returns
    if (in_req) begin
      acc_q <= '0;
    end else if (rd_pend_q) begin
      acc_q <= acc_q + AccW'(AccW'(rd_data) * AccW'(wt_q));
    end
    if (avg_done) begin
      avg_q <= avg_quot;
    end
    if (out_load) begin
      out_avg_q <= avg_q;
      out_chg_q <= change;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {{(24 - LuxW){1'b0}}, out_avg_q};
  assign m_axis_tuser[0] = out_chg_q;

`ifndef SYNTHESIS
  // Lux divider answers only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lux_done |-> (state_q == ST_LUX))
    else $error("lux quotient outside lux wait");

  // Average divider answers only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_done |-> (state_q == ST_AVG_WAIT))
    else $error("average quotient outside average wait");

  // Write pointer stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LastSlot)
    else $error("write slot out of range");

  // Slot moves only when a valid reading's result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q != $past(slot_q)) |-> $past(out_load && !err_q))
    else $error("write slot moved unexpectedly");
`endif

endmodule
